[hw/rtl/char_lcd_shadow_buffer_refresh_unit_defines.svh]
// Assertion macros for the character display refresh unit.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef CHAR_LCD_SHADOW_BUFFER_REFRESH_UNIT_DEFINES_SVH
`define CHAR_LCD_SHADOW_BUFFER_REFRESH_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside of reset.
`define CLSBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CLSBR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLSBR_ASSERT(lbl, prop, msg)
`define CLSBR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hw/rtl/clsbr_pkg.sv]
// Shared types and constants of the character display refresh unit.
// No dependencies.
package clsbr_pkg;

  // Default display geometry
  localparam int ROWS_DEF = 2;
  localparam int COLS_DEF = 16;

  // Fill code of a cleared cell
  localparam logic [7:0] SPACE_CODE = 8'h20;

  // Result kinds
  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOCATE  = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_REFRESH = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_CMP,
    ST_MOVE,
    ST_CHAR,
    ST_FLUSH
  } state_t;

  // One display result
  typedef struct packed {
    logic       kind;
    logic [3:0] col;
    logic       row;
    logic [7:0] chr;
  } res_t;

endpackage

[hw/rtl/char_lcd_shadow_buffer_refresh_unit.sv]
// Top level of the character display refresh unit: frame and shadow memories
// and the sequencer that walks them. Uses clsbr_pkg and the defines header.
//
// The block holds a ROWS x COLS character frame and a shadow of what the
// display shows, and turns refresh commands into a stream that opens with a
// cursor move to the row's first cell, then cursor moves and characters for
// the cells that changed, the final one marked by m_tlast. Locate and write
// are taken while idle. Clear sweeps the frame memory with spaces, one cell
// a cycle, accepting nothing meanwhile. A refresh of a valid row reads and
// then compares each column in the registered-read memories, and passes each
// result through the single output register, stalling while m_tready is low.
// A refresh of a row out of range gives nothing. After reset both memories
// read as zero.
`include "char_lcd_shadow_buffer_refresh_unit_defines.svh"

module char_lcd_shadow_buffer_refresh_unit
  import clsbr_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // col[7:0], row[15:8], character[23:16]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_col[3:0], out_row[4], out_char[12:5], zero[15:13]
  output logic        m_tuser,   // kind[0]
  output logic        m_tlast
);

  localparam int CELLS  = ROWS * COLS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Input fields
  cmd_t       cmd;
  logic [7:0] in_col;
  logic [7:0] in_row;
  logic [7:0] in_char;

  assign cmd     = cmd_t'(s_tuser);
  assign in_col  = s_tdata[7:0];
  assign in_row  = s_tdata[15:8];
  assign in_char = s_tdata[23:16];

  // State
  state_t state, state_next;
  logic [7:0]        cursor_col;
  logic [7:0]        cursor_row;
  logic              run_flag;
  logic [ROW_W-1:0]  ref_row;
  logic [COL_W-1:0]  x;
  logic [CELL_W-1:0] clr_addr;
  logic [7:0]        char_q;
  res_t              pend;
  res_t              m_res;

  // Memories with per-entry valid bits
  logic [7:0]       frame_mem  [CELLS];
  logic [7:0]       shadow_mem [CELLS];
  logic [CELLS-1:0] frame_vld;
  logic [CELLS-1:0] shadow_vld;
  logic [7:0]       frame_q;
  logic [7:0]       shadow_q;
  logic             frame_vld_q;
  logic             shadow_vld_q;

  // Control
  logic              accept;
  logic              out_free;
  logic              push;
  logic              last_col;
  logic              col_step;
  logic              cell_diff;
  logic              write_ok;
  logic              ref_ok;
  logic              fwr_en;
  logic [CELL_W-1:0] fwr_addr;
  logic [7:0]        fwr_data;
  logic [CELL_W-1:0] cell_addr;
  logic [CELL_W-1:0] cur_addr;
  logic [7:0]        frame_d;
  logic [7:0]        shadow_d;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign last_col  = (x == COL_W'(COLS - 1));
  assign write_ok  = (cursor_col < 8'(COLS)) && (cursor_row < 8'(ROWS));
  assign ref_ok    = (in_row < 8'(ROWS));
  assign cell_addr = CELL_W'(int'(ref_row) * COLS + int'(x));
  assign cur_addr  = CELL_W'(int'(cursor_row) * COLS + int'(cursor_col));
  assign frame_d   = frame_vld_q ? frame_q : 8'h00;
  assign shadow_d  = shadow_vld_q ? shadow_q : 8'h00;
  assign cell_diff = (frame_d != shadow_d);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_CLEAR) begin
            state_next = ST_CLR;
          end else if (cmd == CMD_REFRESH && ref_ok) begin
            state_next = ST_RD;
          end
        end
      end
      ST_CLR: begin
        if (clr_addr == CELL_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD: state_next = ST_CMP;
      ST_CMP: begin
        if (cell_diff) begin
          state_next = run_flag ? ST_CHAR : ST_MOVE;
        end else begin
          state_next = last_col ? ST_FLUSH : ST_RD;
        end
      end
      ST_MOVE: begin
        if (out_free) begin
          state_next = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (out_free) begin
          state_next = last_col ? ST_FLUSH : ST_RD;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    col_step = 1'b0;
    fwr_en   = 1'b0;
    fwr_addr = cur_addr;
    fwr_data = in_char;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        fwr_en   = accept && (cmd == CMD_WRITE) && write_ok;
      end
      ST_CLR: begin
        fwr_en   = 1'b1;
        fwr_addr = clr_addr;
        fwr_data = SPACE_CODE;
      end
      ST_CMP:   col_step = !cell_diff && !last_col;
      ST_MOVE:  push = out_free;
      ST_CHAR: begin
        push     = out_free;
        col_step = out_free && !last_col;
      end
      ST_FLUSH: push = out_free;
      default: ;
    endcase
  end

  // Hold sequencer and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
      run_flag   <= 1'b0;
      clr_addr   <= '0;
      x          <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (cmd)
          CMD_LOCATE: begin
            cursor_col <= in_col;
            cursor_row <= in_row;
          end
          CMD_WRITE: begin
            if (write_ok) begin
              if (cursor_col == 8'(COLS - 1)) begin
                cursor_col <= 8'd0;
                cursor_row <= (cursor_row == 8'(ROWS - 1)) ? 8'd0 : cursor_row + 8'd1;
              end else begin
                cursor_col <= cursor_col + 8'd1;
              end
            end
          end
          CMD_CLEAR: begin
            cursor_col <= 8'd0;
            cursor_row <= 8'd0;
            clr_addr   <= '0;
          end
          CMD_REFRESH: x <= '0;
          default: ;
        endcase
      end
      if (state == ST_CLR) begin
        clr_addr <= clr_addr + CELL_W'(1);
      end
      if (state == ST_CMP) begin
        run_flag <= cell_diff;
      end
      if (col_step) begin
        x <= x + COL_W'(1);
      end
    end
  end

  // Capture refresh row, changed character and pending result
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_REFRESH && ref_ok) begin
      ref_row  <= ROW_W'(in_row);
      pend     <= '{kind: KIND_MOVE, col: 4'd0, row: in_row[0], chr: 8'h00};
    end
    if (state == ST_CMP) begin
      char_q <= frame_d;
    end
    if (state == ST_MOVE && out_free) begin
      pend <= '{kind: KIND_MOVE, col: 4'(x), row: ref_row[0], chr: 8'h00};
    end
    if (state == ST_CHAR && out_free) begin
      pend <= '{kind: KIND_CHAR, col: 4'd0, row: 1'b0, chr: char_q};
    end
  end

  // Output register: the pending result moves here when a newer one arrives or the run is flushed
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_res   <= pend;
      m_tlast <= (state == ST_FLUSH);
    end
  end

  assign m_tuser = m_res.kind;
  assign m_tdata = {3'b000, m_res.chr, m_res.row, m_res.col};

  // Valid bits: reset reads as zero until an entry is written
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_vld  <= '0;
      shadow_vld <= '0;
    end else begin
      if (fwr_en) begin
        frame_vld[fwr_addr] <= 1'b1;
      end
      if (state == ST_CMP && cell_diff) begin
        shadow_vld[cell_addr] <= 1'b1;
      end
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fwr_en) begin
      frame_mem[fwr_addr] <= fwr_data;
    end
    if (state == ST_RD) begin
      frame_q     <= frame_mem[cell_addr];
      frame_vld_q <= frame_vld[cell_addr];
    end
  end

  // Shadow memory: copy changed cells back during the compare
  always_ff @(posedge clk) begin
    if (state == ST_CMP && cell_diff) begin
      shadow_mem[cell_addr] <= frame_d;
    end
    if (state == ST_RD) begin
      shadow_q     <= shadow_mem[cell_addr];
      shadow_vld_q <= shadow_vld[cell_addr];
    end
  end

  // Checks
  `CLSBR_ASSERT(a_cmp_after_rd, state == ST_CMP |-> $past(state) == ST_RD, "compare without read")
  `CLSBR_ASSERT(a_flush_last, (state == ST_FLUSH && out_free) |=> (state == ST_IDLE && m_tvalid && m_tlast), "refresh run not closed with last")
  `CLSBR_ASSERT(a_no_frame_write_in_refresh, (state != ST_IDLE && state != ST_CLR) |-> !fwr_en, "frame written during refresh")
  `CLSBR_ASSERT_RST(a_reset_out_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

[tb/tb_char_lcd_shadow_buffer_refresh_unit.sv]
// Self-checking testbench for the character display refresh unit; needs clsbr_pkg
// and the top. A directed table, then random command streams, are checked against
// a behavioral copy of the frame/shadow logic; typed rows give their own results.
module tb_char_lcd_shadow_buffer_refresh_unit;
  import clsbr_pkg::*;

  localparam int N_ROWS      = ROWS_DEF;
  localparam int N_COLS      = COLS_DEF;
  localparam int N_CELLS     = N_ROWS * N_COLS;
  localparam int PHASE_ITEMS = 76;
  localparam int DRAIN_CYC   = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N       = 25;

  // One display command as seen on the result stream
  typedef struct packed {
    logic       kind;
    logic [3:0] col;
    logic       row;
    logic [7:0] chr;
    logic       last;
  } disp_t;

  // One row of the directed table; res is used only when typed and has_res are set
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] chr;
    bit         typed;
    bit         has_res;
    disp_t      res;
  } stim_row_t;

  localparam disp_t NO_RES    = '0;
  localparam disp_t HOME_ROW0 = '{KIND_MOVE, 4'd0, 1'b0, 8'h00, 1'b1};
  localparam disp_t HOME_ROW1 = '{KIND_MOVE, 4'd0, 1'b1, 8'h00, 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // col[7:0], row[15:8], character[23:16]
  logic [1:0]  s_tuser = '0;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // out_col[3:0], out_row[4], out_char[12:5], zero[15:13]
  logic        m_tuser;        // kind[0]
  logic        m_tlast;

  // Predicted display state
  logic [7:0] frame_mem [N_CELLS];
  logic [7:0] shown_mem [N_CELLS];
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  bit         in_run;

  disp_t pending_disp [$];
  disp_t step_disp [$];
  int    mismatches = 0;
  int    cycles = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;

  int send_pct  [4] = '{0, 68, 0, 35};
  int stall_tab [4] = '{0, 0, 68, 35};

  stim_row_t dir_tab [DIR_N] = '{
    '{CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, HOME_ROW0},
    '{CMD_REFRESH, 8'h00, 8'h01, 8'h00, 1'b1, 1'b1, HOME_ROW1},
    '{CMD_REFRESH, 8'h00, 8'h02, 8'h00, 1'b1, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_LOCATE,  8'h0F, 8'h01, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'hA5, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h41, 1'b0, 1'b0, NO_RES},
    '{CMD_LOCATE,  8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h55, 1'b0, 1'b0, NO_RES},
    '{CMD_LOCATE,  8'h10, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h7E, 1'b0, 1'b0, NO_RES},
    '{CMD_LOCATE,  8'h00, 8'h02, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h7E, 1'b0, 1'b0, NO_RES},
    '{CMD_LOCATE,  8'h03, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h80, 1'b0, 1'b0, NO_RES},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h01, 1'b0, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, HOME_ROW0},
    '{CMD_CLEAR,   8'hAA, 8'h55, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, NO_RES},
    '{CMD_REFRESH, 8'hAA, 8'h01, 8'h55, 1'b1, 1'b1, HOME_ROW1}
  };

  char_lcd_shadow_buffer_refresh_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the predicted state; results land in step_disp
  task automatic apply_command(input cmd_t cmd, input logic [7:0] col,
                               input logic [7:0] row, input logic [7:0] chr);
    int    idx;
    disp_t d;
    step_disp.delete();
    case (cmd)
      CMD_LOCATE: begin
        cur_col = col;
        cur_row = row;
      end
      CMD_WRITE: begin
        if (cur_col < N_COLS && cur_row < N_ROWS) begin
          idx = cur_row * N_COLS + cur_col;
          frame_mem[idx] = chr;
          cur_col = cur_col + 8'd1;
          if (cur_col == N_COLS) begin
            cur_col = '0;
            cur_row = cur_row + 8'd1;
            if (cur_row == N_ROWS) cur_row = '0;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < N_CELLS; i++) frame_mem[i] = SPACE_CODE;
        cur_col = '0;
        cur_row = '0;
      end
      default: begin
        if (row < N_ROWS) begin
          d = '{KIND_MOVE, 4'd0, row[0], 8'h00, 1'b0};
          step_disp.push_back(d);
          for (int x = 0; x < N_COLS; x++) begin
            idx = row * N_COLS + x;
            if (frame_mem[idx] != shown_mem[idx]) begin
              if (!in_run) begin
                d = '{KIND_MOVE, 4'(x), row[0], 8'h00, 1'b0};
                step_disp.push_back(d);
              end
              d = '{KIND_CHAR, 4'd0, 1'b0, frame_mem[idx], 1'b0};
              step_disp.push_back(d);
              shown_mem[idx] = frame_mem[idx];
              in_run = 1'b1;
            end else begin
              in_run = 1'b0;
            end
          end
          step_disp[step_disp.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  // Drop valid through random gaps, then wait for the transfer
  task automatic send_item(input cmd_t cmd, input logic [7:0] col,
                           input logic [7:0] row, input logic [7:0] chr);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {chr, row, col};
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : watch_results
    disp_t got;
    disp_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[12:5], m_tlast};
      if (pending_disp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind=%0d col=%0d row=%0d chr=%h last=%0d",
                 $time, got.kind, got.col, got.row, got.chr, got.last);
        mismatches++;
      end else begin
        want = pending_disp.pop_front();
        if (got.kind != want.kind || got.col != want.col || got.row != want.row ||
            got.chr != want.chr || got.last != want.last) begin
          $display("%0t: expected kind=%0d col=%0d row=%0d chr=%h last=%0d",
                   $time, want.kind, want.col, want.row, want.chr, want.last);
          $display("%0t:   actual kind=%0d col=%0d row=%0d chr=%h last=%0d",
                   $time, got.kind, got.col, got.row, got.chr, got.last);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    cmd_t       cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] chr;
    int         pick;
    for (int i = 0; i < N_CELLS; i++) begin
      frame_mem[i] = '0;
      shown_mem[i] = '0;
    end
    cur_col = '0;
    cur_row = '0;
    in_run  = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].cmd, dir_tab[i].col, dir_tab[i].row, dir_tab[i].chr);
      apply_command(dir_tab[i].cmd, dir_tab[i].col, dir_tab[i].row, dir_tab[i].chr);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].has_res) pending_disp.push_back(dir_tab[i].res);
      end else begin
        foreach (step_disp[k]) pending_disp.push_back(step_disp[k]);
      end
    end

    // Random streams, one idling and stall profile per phase
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = send_pct[ph];
      stall_pct = stall_tab[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        col  = 8'($urandom_range(255));
        row  = 8'($urandom_range(255));
        chr  = 8'($urandom_range(255));
        if (pick < 12) begin
          cmd = CMD_LOCATE;
          if ($urandom_range(99) < 85) begin
            col = 8'($urandom_range(N_COLS - 1));
            row = 8'($urandom_range(N_ROWS - 1));
          end
        end else if (pick < 62) begin
          cmd = CMD_WRITE;
          if ($urandom_range(99) < 15) chr = SPACE_CODE;
        end else if (pick < 65) begin
          cmd = CMD_CLEAR;
        end else begin
          cmd = CMD_REFRESH;
          if ($urandom_range(99) < 88) row = 8'($urandom_range(N_ROWS - 1));
        end
        send_item(cmd, col, row, chr);
        apply_command(cmd, col, row, chr);
        foreach (step_disp[k]) pending_disp.push_back(step_disp[k]);
      end
    end
    s_tvalid <= 1'b0;

    // Drain remaining results, then watch for strays
    while (pending_disp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0 && pending_disp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/clsbr_pkg.sv
hw/rtl/char_lcd_shadow_buffer_refresh_unit.sv
tb/tb_char_lcd_shadow_buffer_refresh_unit.sv
